// ===== sv/matrix_rotate_90_buffer_defines.svh =====
// Assertion macros for the 90-degree matrix rotation buffer.
// Expects clk and arst_n in the scope of every use.
`ifndef MATRIX_ROTATE_90_BUFFER_DEFINES_SVH
`define MATRIX_ROTATE_90_BUFFER_DEFINES_SVH

// same-cycle implication
`define MR90_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MR90_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mr90_pkg.sv =====
// Shared constants and controller/datapath interface types for the rotation buffer.
// No dependencies.
`default_nettype none
package mr90_pkg;
	localparam int unsigned MAX_SIZE    = 8;
	localparam int unsigned STORE_DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned CNT_W       = ADDR_W + 1;
	localparam int unsigned RC_W        = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int unsigned SIZE_W      = 4;
	localparam int unsigned DATA_W      = 32;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

	typedef struct packed {
		logic load;
		logic emit_start;
		logic emit_step;
	} dp_cmd_t;

	typedef struct packed {
		logic matrix_full;
		logic emit_last;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== sv/mr90_dpath.sv =====
// Datapath: size register, element store, load counter, rotation address walk, result register.
// Depends on mr90_pkg.
`default_nettype none
module mr90_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [mr90_pkg::SIZE_W-1:0]       cfg_data,
	input  wire logic signed [mr90_pkg::DATA_W-1:0] element_value,
	input  wire mr90_pkg::dp_cmd_t                 cmd,
	output mr90_pkg::dp_sts_t                      sts,
	output logic                                   result_valid,
	output logic signed [mr90_pkg::DATA_W-1:0]     rotated_value,
	output logic                                   last_of_matrix
);
	logic [mr90_pkg::SIZE_W-1:0]   size_q;
	logic [mr90_pkg::SIZE_W-1:0]   n_eff;
	logic [2*mr90_pkg::SIZE_W-1:0] n_sq;
	logic [mr90_pkg::CNT_W-1:0]    total;
	logic [mr90_pkg::CNT_W-1:0]    base_full;
	logic [mr90_pkg::ADDR_W-1:0]   load_cnt_q;
	logic [mr90_pkg::SIZE_W-1:0]   n_q;
	logic [mr90_pkg::RC_W-1:0]     row_q;
	logic [mr90_pkg::RC_W-1:0]     col_q;
	logic [mr90_pkg::ADDR_W-1:0]   src_q;
	logic [mr90_pkg::ADDR_W-1:0]   base_q;
	logic                          col_end;
	logic [mr90_pkg::DATA_W-1:0]   mem [mr90_pkg::STORE_DEPTH];
	logic [mr90_pkg::DATA_W-1:0]   rd_data_s1;
	logic                          vld_s1;
	logic                          last_s1;

	always_comb begin
		n_eff = size_q;
		if (size_q == '0) begin
			n_eff = mr90_pkg::SIZE_W'(1);
		end else if (size_q > mr90_pkg::SIZE_W'(mr90_pkg::MAX_SIZE)) begin
			n_eff = mr90_pkg::SIZE_W'(mr90_pkg::MAX_SIZE);
		end
	end

	assign n_sq      = n_eff * n_eff;
	assign total     = mr90_pkg::CNT_W'(n_sq);
	assign base_full = total - mr90_pkg::CNT_W'(n_eff);

	assign sts.matrix_full = ({1'b0, load_cnt_q} + mr90_pkg::CNT_W'(1)) >= total;
	assign col_end         = mr90_pkg::SIZE_W'(col_q) == (n_q - mr90_pkg::SIZE_W'(1));
	assign sts.emit_last   = col_end && (mr90_pkg::SIZE_W'(row_q) == (n_q - mr90_pkg::SIZE_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= mr90_pkg::SIZE_RESET;
			load_cnt_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (cmd.load) begin
				load_cnt_q <= sts.matrix_full ? '0 : load_cnt_q + mr90_pkg::ADDR_W'(1);
			end
			vld_s1 <= cmd.emit_step;
		end
	end

	// walk source addresses column-major from the bottom row upward
	always_ff @(posedge clk) begin
		if (cmd.emit_start) begin
			n_q    <= n_eff;
			row_q  <= '0;
			col_q  <= '0;
			base_q <= mr90_pkg::ADDR_W'(base_full);
			src_q  <= mr90_pkg::ADDR_W'(base_full);
		end else if (cmd.emit_step) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_q + mr90_pkg::RC_W'(1);
				src_q <= base_q + mr90_pkg::ADDR_W'(row_q) + mr90_pkg::ADDR_W'(1);
			end else begin
				col_q <= col_q + mr90_pkg::RC_W'(1);
				src_q <= src_q - mr90_pkg::ADDR_W'(n_q);
			end
		end
		last_s1 <= sts.emit_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[load_cnt_q] <= element_value;
		end
		if (cmd.emit_step) begin
			rd_data_s1 <= mem[src_q];
		end
	end

	assign result_valid   = vld_s1;
	assign rotated_value  = rd_data_s1;
	assign last_of_matrix = last_s1;
endmodule
`default_nettype wire

// ===== sv/mr90_ctrl.sv =====
// Controller: load/emit state machine driving the rotation datapath.
// Depends on mr90_pkg and matrix_rotate_90_buffer_defines.svh.
`default_nettype none
`include "matrix_rotate_90_buffer_defines.svh"
module mr90_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire mr90_pkg::dp_sts_t sts,
	output mr90_pkg::dp_cmd_t      cmd,
	output logic                   busy
);
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load       = start;
				cmd.emit_start = start && sts.matrix_full;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (cmd.emit_start) begin
						state_q <= ST_EMIT;
						busy_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (sts.emit_last) begin
						state_q <= ST_LOAD;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	`MR90_ASSERT_NEXT(a_full_enters_emit, start && !busy && sts.matrix_full, busy, "full matrix did not start emission")
	`MR90_ASSERT_NEXT(a_emit_holds, busy && !sts.emit_last, busy && cmd.emit_step, "emission ended early")
	`MR90_ASSERT_NEXT(a_emit_ends, busy && sts.emit_last, !busy, "emission overran last element")
	`MR90_ASSERT_NOW(a_no_load_in_emit, busy, !cmd.load && !cmd.emit_start, "load while emitting")
endmodule
`default_nettype wire

// ===== sv/matrix_rotate_90_buffer.sv =====
// Channel     | Signals                                   | Handshake
// element in  | start, busy, element_value                | taken when start && !busy
// result out  | result_valid, rotated_value, last_of_matrix | result_valid per element, no stall
// size cfg    | cfg_valid, cfg_ready, cfg_data            | written when cfg_valid && cfg_ready
//
// Each element is stored when taken. The n*n-th element starts emission: busy rises while the
// single store read port walks the rotated order, and results follow in the cycle after, on
// the registered read data.
// Reset: size 8, load count zero; store contents are undefined until written.
// The result side cannot stall; cfg_ready is always high.
// Top level: mr90_ctrl and mr90_dpath, both over mr90_pkg.
`default_nettype none
module matrix_rotate_90_buffer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [mr90_pkg::DATA_W-1:0]  element_value,
	output logic                                     result_valid,
	output logic signed [mr90_pkg::DATA_W-1:0]       rotated_value,
	output logic                                     last_of_matrix,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mr90_pkg::SIZE_W-1:0]         cfg_data
);
	mr90_pkg::dp_cmd_t cmd;
	mr90_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	mr90_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	mr90_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.element_value  (element_value),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result_valid),
		.rotated_value  (rotated_value),
		.last_of_matrix (last_of_matrix)
	);
endmodule
`default_nettype wire

// ===== tb/matrix_rotate_90_buffer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for matrix_rotate_90_buffer: watches the element, size and result channels,
// keeps its own copy of the element store and predicts every rotated matrix in order.
// Depends on mr90_pkg.
module matrix_rotate_90_buffer_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               busy,
	input  wire logic signed [mr90_pkg::DATA_W-1:0] element_value,
	input  wire logic                               result_valid,
	input  wire logic signed [mr90_pkg::DATA_W-1:0] rotated_value,
	input  wire logic                               last_of_matrix,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [mr90_pkg::SIZE_W-1:0]        cfg_data,
	output int                                      mismatch_count,
	output int                                      outstanding_count
);
	typedef struct packed {
		logic signed [mr90_pkg::DATA_W-1:0] value;
		logic                               last;
	} rotated_elem_t;

	logic signed [mr90_pkg::DATA_W-1:0] element_copy [mr90_pkg::STORE_DEPTH];
	int unsigned                        fill_count;
	logic [mr90_pkg::SIZE_W-1:0]        size_reg;
	rotated_elem_t                      rotation_q [$];

	function automatic int unsigned active_size(logic [mr90_pkg::SIZE_W-1:0] sz);
		if (sz == '0)
			return 1;
		if (sz > mr90_pkg::SIZE_W'(mr90_pkg::MAX_SIZE))
			return mr90_pkg::MAX_SIZE;
		return 32'(sz);
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic store_element(logic signed [mr90_pkg::DATA_W-1:0] v);
		int unsigned n;
		int unsigned total;
		int unsigned r;
		int unsigned c;
		rotated_elem_t e;
		n = active_size(size_reg);
		total = n * n;
		element_copy[mr90_pkg::ADDR_W'(fill_count)] = v;
		if (fill_count + 1 < total) begin
			fill_count++;
			return;
		end
		fill_count = 0;
		for (r = 0; r < n; r++) begin
			for (c = 0; c < n; c++) begin
				e.value = element_copy[mr90_pkg::ADDR_W'((n - 1 - c) * n + r)];
				e.last  = (r == n - 1) && (c == n - 1);
				rotation_q.push_back(e);
			end
		end
	endtask

	task automatic check_rotated();
		rotated_elem_t e;
		if (rotation_q.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing expected", rotated_value));
			return;
		end
		e = rotation_q.pop_front();
		if (rotated_value !== e.value)
			report_mismatch($sformatf("rotated_value %0d, expected %0d",
				rotated_value, e.value));
		if (last_of_matrix !== e.last)
			report_mismatch($sformatf("last_of_matrix %0b, expected %0b",
				last_of_matrix, e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count = 0;
			size_reg = mr90_pkg::SIZE_RESET;
			rotation_q.delete();
			mismatch_count = 0;
			outstanding_count = 0;
		end else begin
			if (result_valid)
				check_rotated();
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (start && !busy)
				store_element(element_value);
			outstanding_count = rotation_q.size();
		end
	end
endmodule

// ===== tb/matrix_rotate_90_buffer_tb.sv =====
`timescale 1ns / 100ps
// Top of the rotation buffer testbench: clock, reset, element and size stimulus, verdict.
// Instantiates matrix_rotate_90_buffer and matrix_rotate_90_buffer_checker; uses mr90_pkg.
module matrix_rotate_90_buffer_tb;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_ITEMS = 330;

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [mr90_pkg::DATA_W-1:0] element_value = '0;
	logic                               result_valid;
	logic signed [mr90_pkg::DATA_W-1:0] rotated_value;
	logic                               last_of_matrix;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [mr90_pkg::SIZE_W-1:0]        cfg_data = '0;
	int                                 mismatch_count;
	int                                 outstanding_count;
	int unsigned                        cycle_count = 0;
	int unsigned                        idle_pct = 0;

	matrix_rotate_90_buffer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.element_value (element_value),
		.result_valid  (result_valid),
		.rotated_value (rotated_value),
		.last_of_matrix(last_of_matrix),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	matrix_rotate_90_buffer_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.element_value    (element_value),
		.result_valid     (result_valid),
		.rotated_value    (rotated_value),
		.last_of_matrix   (last_of_matrix),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.outstanding_count(outstanding_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_element(logic signed [mr90_pkg::DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		element_value <= v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// hold off until the last rotated element has come out
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(logic [mr90_pkg::SIZE_W-1:0] sz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= sz;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [mr90_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			4: return $urandom_range(15);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int unsigned                 phase;
		int unsigned                 phase_sent;
		int unsigned                 n;
		int unsigned                 matrices;
		logic [mr90_pkg::SIZE_W-1:0] sz;
		bit                          first_pick;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one by one matrices at the data extremes
		write_size(mr90_pkg::SIZE_W'(1));
		send_element(32'h8000_0000);
		send_element(32'h7fff_ffff);
		send_element('0);
		send_element('1);
		// size zero runs as one by one
		write_size(mr90_pkg::SIZE_W'(0));
		send_element(32'h1234_5678);
		send_element(32'hfedc_ba98);
		write_size(mr90_pkg::SIZE_W'(2));
		send_element(32'h5555_5555);
		send_element(32'haaaa_aaaa);
		send_element(32'h0000_0001);
		send_element(32'h8000_0001);
		// oversize clamps to eight, then shrink mid-matrix
		write_size(mr90_pkg::SIZE_W'(15));
		repeat (5) send_element($urandom());
		write_size(mr90_pkg::SIZE_W'(2));
		send_element($urandom());
		// grow mid-matrix
		write_size(mr90_pkg::SIZE_W'(2));
		repeat (2) send_element($urandom());
		write_size(mr90_pkg::SIZE_W'(3));
		repeat (7) send_element(pick_value());

		first_pick = 1'b1;
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 21 : (phase == 1) ? 47 : 0;
			phase_sent = 0;
			while (phase_sent < RANDOM_ITEMS / 3) begin
				if (first_pick)
					n = mr90_pkg::MAX_SIZE;
				else if ($urandom_range(3) != 0)
					n = $urandom_range(1, 4);
				else
					n = $urandom_range(5, mr90_pkg::MAX_SIZE);
				first_pick = 1'b0;
				if (n == 1)
					sz = mr90_pkg::SIZE_W'($urandom_range(1));
				else if (n == mr90_pkg::MAX_SIZE)
					sz = mr90_pkg::SIZE_W'($urandom_range(mr90_pkg::MAX_SIZE, 15));
				else
					sz = mr90_pkg::SIZE_W'(n);
				write_size(sz);
				matrices = (n > 4) ? 1 : $urandom_range(1, 3);
				repeat (matrices * n * n) begin
					send_element(pick_value());
					phase_sent++;
				end
				// leave a partial matrix behind for the next size change
				if (n > 1 && $urandom_range(3) == 0) begin
					repeat ($urandom_range(1, n * n - 1)) begin
						send_element(pick_value());
						phase_sent++;
					end
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && outstanding_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/mr90_pkg.sv
sv/mr90_dpath.sv
sv/mr90_ctrl.sv
sv/matrix_rotate_90_buffer.sv
tb/matrix_rotate_90_buffer_checker.sv
tb/matrix_rotate_90_buffer_tb.sv
